@@ rtl/assert_macros.svh @@
// Assertion macros for the set table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RST_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define RST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/rst_pkg.sv @@
// Types and codes for the randomized set table.
package rst_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_PICK   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    localparam int unsigned DRAW_BITS = 16;
    localparam int unsigned SIZE_BITS = 5;
    localparam int unsigned DATA_BITS = 32;

    typedef struct packed {
        cmd_t                        cmd;
        logic signed [DATA_BITS-1:0] value;
        logic [DRAW_BITS-1:0]        random_draw;
    } rst_item_t;

    typedef struct packed {
        logic                        success;
        logic signed [DATA_BITS-1:0] picked_value;
        logic [SIZE_BITS-1:0]        set_size;
        status_t                     status;
    } rst_result_t;

endpackage

@@ rtl/rst_store.sv @@
// Register store with parallel compare over occupied entries and one read port.
module rst_store
    import rst_pkg::*;
#(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned WIDTH = 32,
    parameter int unsigned IDX_W = $clog2(DEPTH),
    parameter int unsigned CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic             clk,
    input  logic [CNT_W-1:0] count,
    input  logic [WIDTH-1:0] key,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    output logic             hit,
    output logic [IDX_W-1:0] hit_addr
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [DEPTH-1:0] match;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_comb
    begin
        match = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            match[i] = (CNT_W'(i) < count) && (mem_reg[i] == key);
        end
    end

    // Values are distinct, so at most one bit of match is set.
    always_comb
    begin
        hit_addr = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (match[i])
            begin
                hit_addr = hit_addr | IDX_W'(i);
            end
        end
    end

    assign hit     = |match;
    assign rd_data = mem_reg[rd_addr];

endmodule

@@ rtl/randomized_set_table.sv @@
// Randomized set table top level: command register, set logic and result register.
// The start beat is registered in valid_reg and then in done_reg, which drives the result strobe done.
// Throughput: one command per cycle; busy stays low, the receiver cannot stall.
// Rate set by the single pass from command register through store compare to result.
// Reset clears the set size and the pipeline valids; store contents stay undefined.
module randomized_set_table
    import rst_pkg::*;
#(
    parameter int unsigned CAPACITY   = 16,
    parameter int unsigned VALUE_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  rst_item_t   item,
    output logic        done,
    output rst_result_t result
);

    `include "assert_macros.svh"

    localparam int unsigned IDX_W  = $clog2(CAPACITY);
    localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
    localparam int unsigned PROD_W = DRAW_BITS + CNT_W;

    logic                    valid_reg;
    rst_item_t               item_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    done_reg;
    rst_result_t             result_reg;
    rst_result_t             result_next;

    logic [VALUE_BITS+31:0]  value_ext;
    logic [VALUE_BITS-1:0]   key;
    logic [PROD_W-1:0]       product;
    logic [CNT_W-1:0]        pick_full;
    logic [CNT_W-1:0]        last_full;
    logic [IDX_W-1:0]        rd_addr;
    logic [VALUE_BITS-1:0]   rd_data;
    logic [VALUE_BITS+31:0]  picked_ext;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [VALUE_BITS-1:0]   wr_data;
    logic                    hit;
    logic [IDX_W-1:0]        hit_addr;
    logic                    full;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            valid_reg <= start;
            done_reg  <= valid_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            item_reg <= item;
        end
        if (valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign value_ext  = {{VALUE_BITS{item_reg.value[DATA_BITS-1]}}, item_reg.value};
    assign key        = value_ext[VALUE_BITS-1:0];
    assign product    = PROD_W'(item_reg.random_draw) * PROD_W'(count_reg);
    assign pick_full  = product[PROD_W-1:DRAW_BITS];
    assign last_full  = count_reg - CNT_W'(1);
    assign rd_addr    = (item_reg.cmd == CMD_REMOVE) ? last_full[IDX_W-1:0]
                                                     : pick_full[IDX_W-1:0];
    assign picked_ext = {32'b0, rd_data};
    assign full       = (count_reg == CNT_W'(CAPACITY));

    rst_store #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_BITS),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_store (
        .clk      (clk),
        .count    (count_reg),
        .key      (key),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .hit      (hit),
        .hit_addr (hit_addr)
    );

    always_comb
    begin
        wr_en                    = 1'b0;
        wr_addr                  = count_reg[IDX_W-1:0];
        wr_data                  = key;
        count_next               = count_reg;
        result_next.success      = 1'b0;
        result_next.picked_value = '0;
        result_next.status       = STATUS_OK;
        if (valid_reg)
        begin
            unique case (item_reg.cmd)
                CMD_INSERT:
                begin
                    if (!hit)
                    begin
                        if (full)
                        begin
                            result_next.status = STATUS_FULL;
                        end
                        else
                        begin
                            wr_en               = 1'b1;
                            count_next          = count_reg + CNT_W'(1);
                            result_next.success = 1'b1;
                        end
                    end
                end
                CMD_REMOVE:
                begin
                    if (hit)
                    begin
                        wr_en               = 1'b1;
                        wr_addr             = hit_addr;
                        wr_data             = rd_data;
                        count_next          = last_full;
                        result_next.success = 1'b1;
                    end
                end
                CMD_PICK:
                begin
                    if (count_reg == '0)
                    begin
                        result_next.status = STATUS_EMPTY;
                    end
                    else
                    begin
                        result_next.success      = 1'b1;
                        result_next.picked_value = picked_ext[DATA_BITS-1:0];
                    end
                end
                default:
                begin
                    result_next.success = 1'b0;
                end
            endcase
        end
        result_next.set_size = SIZE_BITS'(count_next);
    end

    assign done   = done_reg;
    assign result = result_reg;

    `RST_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(CAPACITY), "set size above capacity")
    `RST_ASSERT(a_done_follows, clk, rst_n, valid_reg |=> done_reg, "result beat missing")
    `RST_ASSERT(a_count_step, clk, rst_n, (count_reg != $past(count_reg)) |-> $past(valid_reg), "size moved without a command")
    `RST_ASSERT(a_fail_zero, clk, rst_n, (done_reg && !result_reg.success) |-> (result_reg.picked_value == '0), "failed beat carries a value")
    `RST_ASSERT(a_success_ok, clk, rst_n, (done_reg && result_reg.success) |-> (result_reg.status == STATUS_OK), "successful beat flags a status")

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the randomized set table: directed table, then random commands.
`timescale 1ns / 100ps

module tb_top;
    import rst_pkg::*;

    localparam int unsigned SET_DEPTH    = 16;
    localparam int unsigned POOL_SIZE    = 24;
    localparam int unsigned RANDOM_ITEMS = 1300;
    localparam int unsigned ROW_COUNT    = 16;
    localparam logic [1:0]  CMD_UNKNOWN  = 2'd3;
    localparam logic signed [DATA_BITS-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_BITS-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        cmd_t                        cmd;
        logic signed [DATA_BITS-1:0] value;
        logic [DRAW_BITS-1:0]        draw;
        logic [7:0]                  reps;
        logic                        typed;
        rst_result_t                 want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    rst_item_t   item;
    logic        done;
    rst_result_t result;

    logic signed [DATA_BITS-1:0] held_values [SET_DEPTH];
    int unsigned                 held_count;
    logic signed [DATA_BITS-1:0] value_pool [POOL_SIZE];
    rst_result_t                 expected_results [$];

    int unsigned errors;
    int unsigned beats_sent;
    int unsigned results_checked;
    int unsigned picks_hit;
    int unsigned full_rejects;
    int unsigned empty_picks;

    stim_row_t directed_rows [0:ROW_COUNT-1] = '{
        '{CMD_PICK,   32'sd0,  16'h0000, 8'd1,  1'b1, '{1'b0, 32'sd0,  5'd0,  STATUS_EMPTY}},
        '{CMD_REMOVE, 32'sd5,  16'h0000, 8'd1,  1'b1, '{1'b0, 32'sd0,  5'd0,  STATUS_OK}},
        '{CMD_INSERT, VAL_MIN, 16'h0000, 8'd1,  1'b1, '{1'b1, 32'sd0,  5'd1,  STATUS_OK}},
        '{CMD_INSERT, VAL_MAX, 16'hFFFF, 8'd1,  1'b1, '{1'b1, 32'sd0,  5'd2,  STATUS_OK}},
        '{CMD_INSERT, VAL_MIN, 16'h1234, 8'd1,  1'b1, '{1'b0, 32'sd0,  5'd2,  STATUS_OK}},
        '{cmd_t'(CMD_UNKNOWN), -32'sd1, 16'hFFFF, 8'd1, 1'b1,
          '{1'b0, 32'sd0, 5'd2, STATUS_OK}},
        '{CMD_PICK,   32'sd0,  16'h0000, 8'd1,  1'b1, '{1'b1, VAL_MIN, 5'd2,  STATUS_OK}},
        '{CMD_PICK,   -32'sd1, 16'hFFFF, 8'd1,  1'b1, '{1'b1, VAL_MAX, 5'd2,  STATUS_OK}},
        '{CMD_REMOVE, 32'sd0,  16'h0000, 8'd1,  1'b1, '{1'b0, 32'sd0,  5'd2,  STATUS_OK}},
        '{CMD_INSERT, 32'sd1,  16'h0000, 8'd14, 1'b0, '0},
        '{CMD_INSERT, 32'sd0,  16'h0000, 8'd1,  1'b1, '{1'b0, 32'sd0,  5'd16, STATUS_FULL}},
        '{CMD_INSERT, 32'sd14, 16'h0000, 8'd1,  1'b1, '{1'b0, 32'sd0,  5'd16, STATUS_OK}},
        '{CMD_PICK,   32'sd0,  16'hFFFF, 8'd1,  1'b0, '0},
        '{CMD_REMOVE, VAL_MIN, 16'h0000, 8'd1,  1'b1, '{1'b1, 32'sd0,  5'd15, STATUS_OK}},
        '{CMD_PICK,   32'sd0,  16'h0000, 8'd1,  1'b0, '0},
        '{CMD_REMOVE, 32'sd14, 16'h0000, 8'd1,  1'b0, '0}
    };

    randomized_set_table dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always #5 clk = ~clk;

    function automatic rst_result_t apply_set_command(input rst_item_t beat);
        rst_result_t res;
        int          slot;
        int unsigned idx;
        res        = '0;
        res.status = STATUS_OK;
        slot       = -1;
        for (int i = 0; i < held_count; i++)
        begin
            if (slot < 0 && held_values[i] == beat.value)
                slot = i;
        end
        case (beat.cmd)
            CMD_INSERT:
            begin
                if (slot < 0)
                begin
                    if (held_count >= SET_DEPTH)
                        res.status = STATUS_FULL;
                    else
                    begin
                        held_values[held_count] = beat.value;
                        held_count++;
                        res.success = 1'b1;
                    end
                end
            end
            CMD_REMOVE:
            begin
                if (slot >= 0)
                begin
                    held_values[slot] = held_values[held_count-1];
                    held_count--;
                    res.success = 1'b1;
                end
            end
            CMD_PICK:
            begin
                if (held_count == 0)
                    res.status = STATUS_EMPTY;
                else
                begin
                    idx              = (int'(beat.random_draw) * held_count) >> DRAW_BITS;
                    res.picked_value = held_values[idx];
                    res.success      = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        res.set_size = held_count[SIZE_BITS-1:0];
        return res;
    endfunction

    task automatic issue(input rst_item_t beat, input int gap_cycles,
                         input bit use_typed, input rst_result_t typed_want);
        rst_result_t model_want;
        if (gap_cycles > 0)
        begin
            start <= 1'b0;
            repeat (gap_cycles) @(posedge clk);
        end
        start <= 1'b1;
        item  <= beat;
        do
            @(posedge clk);
        while (busy);
        beats_sent++;
        model_want = apply_set_command(beat);
        expected_results.insert(expected_results.size(), use_typed ? typed_want : model_want);
    endtask

    always @(posedge clk)
    begin : result_check
        rst_result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result beat: %p", result);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                if (result.success !== want.success)
                begin
                    $error("success: expected %0d, got %0d", want.success, result.success);
                    errors++;
                end
                if (result.picked_value !== want.picked_value)
                begin
                    $error("picked_value: expected %0d, got %0d",
                           want.picked_value, result.picked_value);
                    errors++;
                end
                if (result.set_size !== want.set_size)
                begin
                    $error("set_size: expected %0d, got %0d", want.set_size, result.set_size);
                    errors++;
                end
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, result.status);
                    errors++;
                end
                if (want.status == STATUS_FULL)
                    full_rejects++;
                if (want.status == STATUS_EMPTY)
                    empty_picks++;
                if (want.success && want.picked_value != 0)
                    picks_hit++;
            end
        end
    end

    initial
    begin
        #1_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : stimulus
        rst_item_t   beat;
        int unsigned roll;
        int unsigned insert_bias;
        bit          quiet;

        clk        = 1'b0;
        rst_n      = 1'b0;
        start      = 1'b0;
        item       = '0;
        held_count = 0;
        errors     = 0;
        beats_sent = 0;
        results_checked = 0;
        picks_hit    = 0;
        full_rejects = 0;
        empty_picks  = 0;
        insert_bias  = 50;
        quiet        = 1'b0;

        value_pool[0] = VAL_MIN;
        value_pool[1] = VAL_MAX;
        value_pool[2] = 32'sd0;
        value_pool[3] = -32'sd1;
        for (int i = 4; i < POOL_SIZE; i++)
            value_pool[i] = $urandom;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            for (int k = 0; k < directed_rows[r].reps; k++)
            begin
                beat.cmd         = directed_rows[r].cmd;
                beat.value       = directed_rows[r].value + k;
                beat.random_draw = directed_rows[r].draw;
                issue(beat, $urandom_range(0, 4), directed_rows[r].typed,
                      directed_rows[r].want);
            end
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
            begin
                insert_bias = $urandom_range(20, 80);
                quiet       = ($urandom_range(0, 3) == 0);
            end
            roll = $urandom_range(0, 99);
            if (roll < 3)
                beat.cmd = cmd_t'(CMD_UNKNOWN);
            else if (roll < 25)
                beat.cmd = CMD_PICK;
            else if ($urandom_range(0, 99) < insert_bias)
                beat.cmd = CMD_INSERT;
            else
                beat.cmd = CMD_REMOVE;
            roll = $urandom_range(0, 99);
            if (roll < 40 && held_count > 0)
                beat.value = held_values[$urandom_range(0, held_count - 1)];
            else if (roll < 80)
                beat.value = value_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                beat.value = $urandom;
            case ($urandom_range(0, 7))
                0:       beat.random_draw = '0;
                1:       beat.random_draw = '1;
                default: beat.random_draw = DRAW_BITS'($urandom);
            endcase
            issue(beat, quiet ? 0 : $urandom_range(0, 4), 1'b0, '0);
        end

        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Ran %0d commands, checked %0d results.", beats_sent, results_checked);
        $display("Saw %0d nonzero picks, %0d full-set rejects, %0d empty-set picks.",
                 picks_hit, full_rejects, empty_picks);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/rst_pkg.sv
rtl/rst_store.sv
rtl/randomized_set_table.sv
tb/tb_top.sv
